// ===== design/srw_pkg.sv =====
// ----------------------------------------------------------------------------
// srw_pkg: shared types and helpers for the sequence reorder window
// Status codes, request/result/state records, and the wrapping marker
// arithmetic and bit-scan helpers used by the core and the checker.
// ----------------------------------------------------------------------------
package srw_pkg;

  // Window depth: markers 1..WINDOW ahead of expected are held
  localparam int unsigned WINDOW = 32;

  // Number of valid markers (1 .. 2^32-1)
  localparam logic [32:0] SEQ_SPACE = 33'h0_FFFF_FFFF;

  // Timeout register value after reset
  localparam logic [31:0] GAP_TIMEOUT_RST = 32'd1000;

  // Request types
  localparam logic REQ_ADMIT = 1'b0;
  localparam logic REQ_POLL  = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_RELEASED = 3'd0;
  localparam logic [2:0] ST_HELD     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  typedef struct packed {
    logic        req_type;
    logic [31:0] marker;
    logic [63:0] now_ms;
  } srw_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] run_start;
    logic [5:0]  run_length;
  } srw_res_t;

  typedef struct packed {
    logic [31:0] expected;
    logic [31:0] held;
    logic [63:0] deadline;
  } srw_state_t;

  // Advance marker m by n places, wrapping past zero (zero is skipped)
  function automatic logic [31:0] seq_add(logic [31:0] m, logic [6:0] n);
    logic [32:0] x;
    x = {1'b0, m} + 33'(n) - 33'd1;
    if (x >= SEQ_SPACE) begin
      x = x - SEQ_SPACE;
    end
    return x[31:0] + 32'd1;
  endfunction

  // Count of consecutive set bits starting at bit 0 (0..32)
  function automatic logic [5:0] cnt_trail_ones(logic [31:0] b);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 31; i >= 0; i--) begin
      if (!b[i]) n = 6'(i);
    end
    return n;
  endfunction

  // Index of the lowest set bit (32 when none)
  function automatic logic [5:0] cnt_trail_zeros(logic [31:0] b);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 31; i >= 0; i--) begin
      if (b[i]) n = 6'(i);
    end
    return n;
  endfunction

endpackage

// ===== design/srw_core.sv =====
// ----------------------------------------------------------------------------
// srw_core: next-state and result logic of the reorder window
// Classifies one admit or poll request against the current window state
// and produces the updated state and the result item in one pass.
// ----------------------------------------------------------------------------
module srw_core (
  input  srw_pkg::srw_req_t   req_i,
  input  srw_pkg::srw_state_t state_i,
  input  logic [31:0]         gap_timeout_i,
  output srw_pkg::srw_state_t state_o,
  output srw_pkg::srw_res_t   res_o
);
  import srw_pkg::*;

  logic [32:0] diff;
  logic [31:0] fwd;
  logic        in_win;
  logic        behind;
  logic [4:0]  bit_idx;
  logic        bit_held;
  logic        armed;
  logic [64:0] arm_sum;
  logic        arm_ovf;
  logic        poll_due;
  logic [5:0]  skip;
  logic [31:0] rest;
  logic [5:0]  run_ones;
  logic [6:0]  total;
  logic [31:0] first;
  logic [31:0] rel_expected;
  logic [31:0] rel_held;

  // Forward distance from expected to the arriving marker, modulo the space
  always_comb begin
    diff = {1'b0, req_i.marker} - {1'b0, state_i.expected};
    fwd  = diff[32] ? 32'(diff + SEQ_SPACE) : diff[31:0];
  end

  assign in_win   = (fwd != 32'd0) && (fwd <= 32'(WINDOW));
  assign behind   = (33'(fwd) + 33'(WINDOW)) >= SEQ_SPACE;
  assign bit_idx  = 5'(fwd - 32'd1);
  assign bit_held = state_i.held[bit_idx];

  // Deadline arming and its overflow
  assign armed    = state_i.deadline != 64'd0;
  assign arm_sum  = {1'b0, req_i.now_ms} + 65'(gap_timeout_i);
  assign arm_ovf  = arm_sum[64];
  assign poll_due = (state_i.held != 32'd0) && (req_i.now_ms >= state_i.deadline);

  // Release path: a poll first skips the gap up to the lowest held marker
  always_comb begin
    skip         = (req_i.req_type == REQ_POLL) ?
                   cnt_trail_zeros(state_i.held) + 6'd1 : 6'd0;
    rest         = state_i.held >> skip;
    run_ones     = cnt_trail_ones(rest);
    total        = 7'(skip) + 7'(run_ones) + 7'd1;
    first        = seq_add(state_i.expected, 7'(skip));
    rel_expected = seq_add(state_i.expected, total);
    rel_held     = state_i.held >> total;
  end

  // Classify the request and update the window
  always_comb begin
    state_o = state_i;
    res_o   = '{status: ST_HELD, run_start: 32'd0, run_length: 6'd0};
    if (req_i.req_type == REQ_ADMIT) begin
      if (req_i.marker == 32'd0) begin
        res_o.status = ST_INVALID;
      end else if (fwd == 32'd0) begin
        state_o.expected = rel_expected;
        state_o.held     = rel_held;
        if (rel_held == 32'd0) state_o.deadline = 64'd0;
        res_o.status     = ST_RELEASED;
        res_o.run_start  = first;
        res_o.run_length = run_ones + 6'd1;
      end else if (in_win) begin
        if (bit_held) begin
          res_o.status = ST_DUP;
        end else if (!armed && arm_ovf) begin
          res_o.status = ST_OVERFLOW;
        end else begin
          state_o.held[bit_idx] = 1'b1;
          if (!armed) state_o.deadline = arm_sum[63:0];
          res_o.status = ST_HELD;
        end
      end else begin
        res_o.status = behind ? ST_DUP : ST_RANGE;
      end
    end else if (poll_due) begin
      state_o.expected = rel_expected;
      state_o.held     = rel_held;
      res_o.run_start  = first;
      res_o.run_length = run_ones + 6'd1;
      res_o.status     = ST_RELEASED;
      if (rel_held == 32'd0) begin
        state_o.deadline = 64'd0;
      end else if (arm_ovf) begin
        res_o.status = ST_OVERFLOW;
      end else begin
        state_o.deadline = arm_sum[63:0];
      end
    end
  end

endmodule

// ===== design/sequence_reorder_window_unit.sv =====
// ----------------------------------------------------------------------------
// sequence_reorder_window_unit: sequence marker reorder window, top level
// Flow: an accepted item waits in the input register, then passes srw_core
// into the result register once that is free. Throughput: one item per cycle
// unless the receiver stalls; the window update is one pass of srw_core.
// Reset: expected marker 1, nothing held, deadline unarmed, timeout 1000 ms.
// ----------------------------------------------------------------------------
module sequence_reorder_window_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_gap_timeout_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_req_type_i,
  input  logic [31:0] in_marker_i,
  input  logic [63:0] in_now_ms_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_status_o,
  output logic [31:0] out_run_start_o,
  output logic [5:0]  out_run_length_o
);
  import srw_pkg::*;

  logic        in_vld_q, in_vld_d;
  srw_req_t    in_req_q;
  logic        out_vld_q, out_vld_d;
  srw_res_t    out_res_q;
  srw_state_t  state_q, state_d;
  srw_res_t    res_d;
  logic [31:0] gap_timeout_q;
  logic        in_take;
  logic        advance;

  // Move the held item into the result register when it is free
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d = advance ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);

  // Window logic
  srw_core u_core (
    .req_i         (in_req_q),
    .state_i       (state_q),
    .gap_timeout_i (gap_timeout_q),
    .state_o       (state_d),
    .res_o         (res_d)
  );

  // Control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      state_q       <= '{expected: 32'd1, held: 32'd0, deadline: 64'd0};
      gap_timeout_q <= GAP_TIMEOUT_RST;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) gap_timeout_q <= cfg_gap_timeout_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= '{req_type: in_req_type_i, marker: in_marker_i, now_ms: in_now_ms_i};
    end
    if (advance) out_res_q <= res_d;
  end

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_vld_q;
  assign out_status_o     = out_res_q.status;
  assign out_run_start_o  = out_res_q.run_start;
  assign out_run_length_o = out_res_q.run_length;

endmodule

// ===== design/srw_checker.sv =====
// ----------------------------------------------------------------------------
// srw_checker: port-level checks for the reorder window
// Watches the result channel for legal status codes, consistent run
// fields and a stable stalled item; bound to the top level below.
// ----------------------------------------------------------------------------
module srw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  out_status_o,
  input logic [31:0] out_run_start_o,
  input logic [5:0]  out_run_length_o
);
  import srw_pkg::*;

  // Status is one of the defined codes
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_status_o <= ST_OVERFLOW)
    else $error("illegal status code");

  // Held, duplicate, invalid and out-of-range items carry empty run fields
  a_no_run_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == ST_HELD || out_status_o == ST_DUP ||
                    out_status_o == ST_INVALID || out_status_o == ST_RANGE)
    |-> out_run_start_o == 32'd0 && out_run_length_o == 6'd0)
    else $error("run fields set without a release");

  // A release names a valid first marker and a run of 1..33
  a_release_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o == ST_RELEASED
    |-> out_run_start_o != 32'd0 && out_run_length_o != 6'd0 &&
        out_run_length_o <= 6'(WINDOW + 1))
    else $error("malformed released run");

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_status_o) &&
      $stable(out_run_start_o) && $stable(out_run_length_o))
    else $error("stalled result item changed");

endmodule

bind sequence_reorder_window_unit srw_checker u_srw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_status_o     (out_status_o),
  .out_run_start_o  (out_run_start_o),
  .out_run_length_o (out_run_length_o)
);

// ===== tb/srw_result_checker.sv =====
// ----------------------------------------------------------------------------
// srw_result_checker: result predictor and scoreboard for the reorder window
// Watches the configuration, input and result channels of the block, keeps
// its own copy of the window state, predicts one result per accepted item
// and compares each accepted result, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module srw_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration channel
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_gap_timeout_i,
  // input channel
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        in_req_type_i,
  input  logic [31:0] in_marker_i,
  input  logic [63:0] in_now_ms_i,
  // result channel
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  out_status_i,
  input  logic [31:0] out_run_start_i,
  input  logic [5:0]  out_run_length_i,
  // status toward the test top
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          accepted_o,
  output logic [5:0]  status_seen_o,
  output logic [31:0] next_marker_o
);
  import srw_pkg::*;

  localparam logic [63:0] MARKER_SPACE = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] TIME_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;

  // Predicted results not yet seen on the output
  srw_res_t    expected_runs[$];

  // Shadow window state
  logic [31:0] next_marker;
  logic [31:0] held_map;
  logic [63:0] deadline;
  logic [31:0] gap_tmo;

  int          fails;
  int          checked;
  int          accepted;
  logic [5:0]  seen;

  // Advance a marker by n places, skipping zero on wrap
  function automatic logic [31:0] marker_plus(logic [31:0] m, logic [31:0] n);
    logic [63:0] idx;
    idx = ({32'd0, m} - 64'd1 + {32'd0, n}) % MARKER_SPACE;
    return idx[31:0] + 32'd1;
  endfunction

  // Arm the gap deadline, refuse when the sum does not fit in 64 bits
  function automatic bit arm_gap(logic [63:0] now);
    if (now > TIME_MAX - {32'd0, gap_tmo}) return 1'b0;
    deadline = now + {32'd0, gap_tmo};
    return 1'b1;
  endfunction

  // Release first plus the unbroken run of held successors in bits
  function automatic srw_res_t release_from(logic [31:0] first, logic [31:0] bits);
    int unsigned ones;
    srw_res_t    r;
    ones = 0;
    while (ones < 32 && bits[ones]) ones++;
    next_marker = marker_plus(first, ones + 1);
    held_map    = bits >> (ones + 1);
    if (held_map == 32'd0) deadline = 64'd0;
    r.status     = ST_RELEASED;
    r.run_start  = first;
    r.run_length = 6'(ones + 1);
    return r;
  endfunction

  // Work out the result of one item and advance the shadow state
  function automatic srw_res_t predict_run(logic req, logic [31:0] mk, logic [63:0] now);
    srw_res_t    r;
    logic [63:0] e_idx;
    logic [63:0] m_idx;
    logic [63:0] ahead;
    logic [31:0] slot;
    int unsigned low;
    r.status     = ST_HELD;
    r.run_start  = 32'd0;
    r.run_length = 6'd0;
    if (req == REQ_ADMIT) begin
      if (mk == 32'd0) begin
        r.status = ST_INVALID;
      end else begin
        e_idx = {32'd0, next_marker} - 64'd1;
        m_idx = {32'd0, mk} - 64'd1;
        ahead = (m_idx >= e_idx) ? m_idx - e_idx : MARKER_SPACE - (e_idx - m_idx);
        if (ahead == 64'd0) begin
          r = release_from(mk, held_map);
        end else if (ahead <= WINDOW) begin
          slot = 32'd1 << (ahead - 64'd1);
          if ((held_map & slot) != 32'd0) begin
            r.status = ST_DUP;
          end else if (deadline == 64'd0 && !arm_gap(now)) begin
            r.status = ST_OVERFLOW;
          end else begin
            held_map = held_map | slot;
            r.status = ST_HELD;
          end
        end else begin
          r.status = (MARKER_SPACE - ahead <= WINDOW) ? ST_DUP : ST_RANGE;
        end
      end
    end else if (held_map != 32'd0 && now >= deadline) begin
      // skip the missing markers up to the lowest held one
      low = 0;
      while (low < 31 && !held_map[low]) low++;
      r = release_from(marker_plus(next_marker, low + 1), held_map >> (low + 1));
      if (held_map != 32'd0 && !arm_gap(now)) r.status = ST_OVERFLOW;
    end
    return r;
  endfunction

  // Track the channels, compare results, predict new ones
  always @(posedge clk_i or negedge rst_ni) begin
    srw_res_t got;
    srw_res_t want;
    if (!rst_ni) begin
      expected_runs.delete();
      next_marker   = 32'd1;
      held_map      = 32'd0;
      deadline      = 64'd0;
      gap_tmo       = GAP_TIMEOUT_RST;
      fails         = 0;
      checked       = 0;
      accepted      = 0;
      seen          = '0;
      fail_count_o  <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
      accepted_o    <= 0;
      status_seen_o <= '0;
      next_marker_o <= 32'd1;
    end else begin
      // compare the accepted result with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got.status     = out_status_i;
        got.run_start  = out_run_start_i;
        got.run_length = out_run_length_i;
        if (expected_runs.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected result: status %0d start %h length %0d",
                     got.status, got.run_start, got.run_length);
          end
          fails++;
        end else begin
          want = expected_runs.pop_front();
          checked++;
          if (got.status !== want.status || got.run_start !== want.run_start ||
              got.run_length !== want.run_length) begin
            if (fails < 10) begin
              $display("mismatch on result %0d: status %0d/%0d start %h/%h length %0d/%0d",
                       checked, want.status, got.status, want.run_start, got.run_start,
                       want.run_length, got.run_length);
              $display("  (expected/actual)");
            end
            fails++;
          end
        end
      end

      // take a new timeout
      if (cfg_valid_i && cfg_ready_i) gap_tmo = cfg_gap_timeout_i;

      // predict the result of an accepted item
      if (in_valid_i && !in_stall_i) begin
        want = predict_run(in_req_type_i, in_marker_i, in_now_ms_i);
        expected_runs.push_back(want);
        seen[want.status] = 1'b1;
        accepted++;
      end

      fail_count_o  <= fails;
      pending_o     <= expected_runs.size();
      checked_o     <= checked;
      accepted_o    <= accepted;
      status_seen_o <= seen;
      next_marker_o <= next_marker;
    end
  end

endmodule

// ===== tb/sequence_reorder_window_unit_test.sv =====
// ----------------------------------------------------------------------------
// sequence_reorder_window_unit_test: stimulus and verdict for the reorder window
// Drives directed corner items, then shuffled marker bursts with gaps and
// duplicates mixed with noise, under several gap timeouts and random idling
// on both channels, one long receiver hold included. The checker predicts
// and compares every result; this module reports the outcome.
// ----------------------------------------------------------------------------
module sequence_reorder_window_unit_test;
  import srw_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 275;
  localparam int HOLD_CYCLES = 400;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_gap_timeout = 32'd0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic        in_req_type     = REQ_ADMIT;
  logic [31:0] in_marker       = 32'd0;
  logic [63:0] in_now_ms       = 64'd0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_run_start;
  logic [5:0]  out_run_length;

  int          fail_count;
  int          pending;
  int          checked;
  int          accepted;
  logic [5:0]  status_seen;
  logic [31:0] window_base;

  // Stimulus bookkeeping
  logic [63:0] clock_ms     = 64'd0;
  logic [31:0] cur_timeout  = GAP_TIMEOUT_RST;
  int          sent         = 0;
  int          settings     = 0;
  bit          idle_on      = 1'b1;
  bit          squeeze_req  = 1'b0;
  bit          squeeze_done = 1'b0;

  always #1 clk_i = ~clk_i;

  sequence_reorder_window_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_gap_timeout_i(cfg_gap_timeout),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_req_type_i    (in_req_type),
    .in_marker_i      (in_marker),
    .in_now_ms_i      (in_now_ms),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_status_o     (out_status),
    .out_run_start_o  (out_run_start),
    .out_run_length_o (out_run_length)
  );

  srw_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_gap_timeout_i(cfg_gap_timeout),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_type_i    (in_req_type),
    .in_marker_i      (in_marker),
    .in_now_ms_i      (in_now_ms),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_status_i     (out_status),
    .out_run_start_i  (out_run_start),
    .out_run_length_i (out_run_length),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .accepted_o       (accepted),
    .status_seen_o    (status_seen),
    .next_marker_o    (window_base)
  );

  // Receiver: random stalls, one long hold on request
  initial begin : receiver
    int hold;
    forever begin
      if (squeeze_req && !squeeze_done) begin
        for (hold = 0; hold < HOLD_CYCLES; hold++) begin
          out_stall <= 1'b1;
          @(posedge clk_i);
        end
        squeeze_done = 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 34);
        @(posedge clk_i);
      end
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("sequence_reorder_window_unit test failed");
    $finish;
  end

  // Offer one item, with a random gap ahead of it, and wait until taken
  task automatic offer(logic req, logic [31:0] mk, logic [63:0] now);
    if (idle_on) begin
      while ($urandom_range(99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_marker   <= mk;
    in_now_ms   <= now;
    do begin
      @(posedge clk_i);
    end while (in_stall);
    sent++;
  endtask

  // Drain all outstanding results, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Write the gap timeout while the block is idle
  task automatic set_timeout(logic [31:0] value);
    drain();
    cfg_valid       <= 1'b1;
    cfg_gap_timeout <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready);
    cfg_valid   <= 1'b0;
    cur_timeout = value;
    settings++;
  endtask

  // Pick a time step that sometimes passes the current deadline
  function automatic logic [63:0] time_step();
    if (cur_timeout <= 32'd100000) return 64'($urandom_range(0, cur_timeout * 2 + 2));
    return 64'($urandom_range(0, 5000));
  endfunction

  // Send a run of markers from the window base, shuffled, reversed or in order,
  // with a missing or repeated marker now and then, and follow it with a few polls
  task automatic burst();
    logic [31:0] order[$];
    logic [31:0] tmp;
    logic [31:0] base;
    int          n;
    int          j;
    int          k;
    int          mode;
    int          polls;
    // hold off until the checker has seen every item sent so far
    while (accepted != sent) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    base = window_base;
    n    = $urandom_range(1, 33);
    mode = $urandom_range(2);
    for (j = 0; j < n; j++) order.push_back(base + 32'(j));
    if (mode == 0) begin
      for (j = n - 1; j > 0; j--) begin
        k        = $urandom_range(j, 0);
        tmp      = order[j];
        order[j] = order[k];
        order[k] = tmp;
      end
    end else if (mode == 1) begin
      // reverse: the base comes last and releases the whole run
      for (j = 0; j < n / 2; j++) begin
        tmp              = order[j];
        order[j]         = order[n - 1 - j];
        order[n - 1 - j] = tmp;
      end
    end
    if (n > 1 && $urandom_range(99) < 30) order.delete($urandom_range(n - 1));
    if ($urandom_range(99) < 20) begin
      order.insert($urandom_range(order.size()), order[$urandom_range(order.size() - 1)]);
    end
    foreach (order[j]) begin
      clock_ms = clock_ms + 64'($urandom_range(0, 3));
      offer(REQ_ADMIT, order[j], clock_ms);
    end
    polls = $urandom_range(0, 3);
    for (j = 0; j < polls; j++) begin
      clock_ms = clock_ms + time_step();
      offer(REQ_POLL, $urandom, clock_ms);
    end
  endtask

  // Send one odd item: bad markers, stray polls, times near the top
  task automatic noise();
    case ($urandom_range(7))
      0: offer(REQ_ADMIT, 32'd0, {$urandom, $urandom});
      1: offer(REQ_ADMIT, $urandom, {$urandom, $urandom});
      2: offer(REQ_ADMIT, window_base - 32'($urandom_range(1, 40)), clock_ms);
      3: offer(REQ_ADMIT, window_base + 32'($urandom_range(33, 80)), clock_ms);
      4: offer(REQ_POLL, $urandom, {$urandom, $urandom});
      5: offer(REQ_POLL, $urandom, 64'hFFFF_FFFF_FFFF_FFFF);
      6: offer(REQ_ADMIT, window_base + 32'($urandom_range(1, 32)),
               64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 2000)));
      default: begin
        clock_ms = clock_ms + time_step();
        offer(REQ_POLL, $urandom, clock_ms);
      end
    endcase
  endtask

  initial begin : stimulus
    logic [31:0] phase_tmo[6];
    int          phase;
    int          phase_start;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners under the reset timeout
    offer(REQ_ADMIT, 32'd1, 64'd0);            // in order: run of one
    offer(REQ_ADMIT, 32'd0, 64'd0);            // marker zero
    offer(REQ_ADMIT, 32'd3, 64'd10);           // ahead: hold and arm
    offer(REQ_ADMIT, 32'd3, 64'd11);           // already held
    offer(REQ_ADMIT, 32'd1, 64'd12);           // just behind
    offer(REQ_ADMIT, 32'hFFFF_FFFF, 64'd12);   // behind across the wrap
    offer(REQ_ADMIT, 32'd35, 64'd13);          // one past the window
    offer(REQ_ADMIT, 32'd34, 64'd13);          // last window slot
    offer(REQ_POLL, 32'hFFFF_FFFF, 64'd500);   // before the deadline
    offer(REQ_POLL, 32'd0, 64'd1010);          // at the deadline: skip and re-arm
    offer(REQ_ADMIT, 32'd2, 64'd1011);         // skipped marker now behind
    offer(REQ_POLL, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    offer(REQ_ADMIT, 32'd36, 64'hFFFF_FFFF_FFFF_FFF0);  // arming overflows
    offer(REQ_ADMIT, 32'd36, 64'hFFFF_FFFF_FFFF_FC17);  // deadline at the top
    offer(REQ_ADMIT, 32'd37, 64'd0);
    offer(REQ_POLL, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    offer(REQ_ADMIT, 32'd40, 64'd0);
    offer(REQ_ADMIT, 32'd42, 64'd0);
    offer(REQ_POLL, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);    // re-arm overflows
    offer(REQ_ADMIT, 32'd38, 64'd1);
    offer(REQ_ADMIT, 32'd41, 64'd1);

    // Zero timeout: a deadline that sums to zero stays unarmed
    set_timeout(32'd0);
    offer(REQ_ADMIT, 32'd44, 64'd0);
    offer(REQ_ADMIT, 32'd45, 64'd5);
    offer(REQ_POLL, 32'd0, 64'd5);

    // Random phases, one per timeout setting
    phase_tmo[0] = 32'd1;
    phase_tmo[1] = 32'hFFFF_FFFF;
    phase_tmo[2] = 32'd0;
    phase_tmo[3] = 32'($urandom_range(2, 300));
    phase_tmo[4] = GAP_TIMEOUT_RST;
    phase_tmo[5] = $urandom;
    for (phase = 0; phase < 6; phase++) begin
      set_timeout(phase_tmo[phase]);
      idle_on     = (phase != 4);
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS) begin
        if (phase == 0 && sent - phase_start >= 100) squeeze_req = 1'b1;
        if ($urandom_range(99) < 75) burst();
        else noise();
      end
    end

    // Wait out the last results
    in_valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
    repeat (8) @(posedge clk_i);

    $display("covered %0d items over %0d timeout settings, %0d results checked",
             sent, settings + 1, checked);
    $display("status codes seen %b (bit per code), long receiver hold %0s",
             status_seen, squeeze_done ? "done" : "missed");
    if (fail_count == 0 && pending == 0) begin
      $display("sequence_reorder_window_unit test passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("sequence_reorder_window_unit test failed");
    end
    $finish;
  end

endmodule
